/* design/assert_macros.svh */
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define BST_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// condition in one cycle implies a condition in the next
`define BST_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: check failed");

`else

`define BST_ASSERT(name, clk, rst, prop)
`define BST_ASSERT_NEXT(name, clk, rst, pre, post)

`endif

`endif

/* design/bst_pkg.sv */
package bst_pkg;

   // fixed field widths
   localparam int KIND_W = 2;
   localparam int VAL_W  = 32;
   localparam int POS_W  = 4;
   localparam int STAT_W = 3;
   localparam int CNT_W  = 5;
   localparam int CAP_W  = 5;
   localparam int CSR_W  = 32;
   localparam int CSR_AW = 3;

   // element store depth, tied to the position and count widths
   localparam int DEPTH  = 16;

   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [STAT_W-1:0] status_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [VAL_W-1:0]  value_type;

   // request kinds
   localparam kind_type KIND_INSERT = 2'd0;
   localparam kind_type KIND_REMOVE = 2'd1;
   localparam kind_type KIND_TEST   = 2'd2;
   localparam kind_type KIND_READ   = 2'd3;

   // response status codes
   localparam status_type STATUS_OK      = 3'd0;
   localparam status_type STATUS_FULL    = 3'd1;
   localparam status_type STATUS_DUP     = 3'd2;
   localparam status_type STATUS_MISSING = 3'd3;
   localparam status_type STATUS_RANGE   = 3'd4;

   // register index (paddr bit 2) and reset value
   localparam logic                 CSR_IDX_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0]     CAP_RESET        = 5'd5;

endpackage

/* design/bounded_set_table_unit.sv */
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_kind, req_value, req_position
// rsp       out        rsp_valid / rsp_stall  rsp_status, rsp_found, rsp_found_index,
//                                             rsp_read_value, rsp_count
// csr       in         apb, pready tied high  capacity at byte address 0
//
// one request at a time: the single read port scans one entry per cycle, and each
// registered read is compared with the request value; a hit stops the scan, a remove
// then moves every later element down one place, and a miss on insert appends it;
// a read fetches one entry; a full insert or out-of-range read skips the scan
// synchronous reset empties the set and sets capacity to 5; no clearing pass
// a stalled response holds in the output register; the next request is accepted meanwhile
`include "assert_macros.svh"

module bounded_set_table_unit import bst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [KIND_W-1:0] req_kind,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic [POS_W-1:0]  req_position,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [STAT_W-1:0] rsp_status,
   output logic              rsp_found,
   output logic [POS_W-1:0]  rsp_found_index,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic [CNT_W-1:0]  rsp_count,
   // configuration port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_W-1:0]  csr_pwdata,
   output logic [CSR_W-1:0]  csr_prdata,
   output logic              csr_pready
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   // control registers
   logic [2:0]       state_ff, state_in;
   logic [CAP_W-1:0] capacity_ff, capacity_in;
   count_type        count_ff, count_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   kind_type         kind_ff, kind_in;
   value_type        value_ff, value_in;
   count_type        scan_ff, scan_in;
   count_type        pend_idx_ff, pend_idx_in;
   status_type       res_status_ff, res_status_in;
   logic             res_found_ff, res_found_in;
   logic [POS_W-1:0] res_index_ff, res_index_in;
   value_type        res_data_ff, res_data_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0] rsp_index_ff, rsp_index_in;
   value_type        rsp_data_ff, rsp_data_in;
   count_type        rsp_count_ff, rsp_count_in;

   // memory port signals
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   value_type        ram_wr_data;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   value_type        ram_rd_data;

   logic full;
   logic issue;
   logic hit;
   logic rsp_free;
   logic csr_wr;

   bst_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_elements (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // status terms
   assign full     = (count_ff >= capacity_ff) || (int'(count_ff) >= DEPTH);
   assign issue    = (scan_ff < count_ff);
   assign hit      = pend_ff && (ram_rd_data == value_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // configuration port
   assign csr_wr      = csr_psel && csr_penable && csr_pwrite && csr_pready
                        && (csr_paddr[2] == CSR_IDX_CAPACITY);
   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr[2] == CSR_IDX_CAPACITY) ? CSR_W'(capacity_ff) : '0;
   assign capacity_in = csr_wr ? csr_pwdata[CAP_W-1:0] : capacity_ff;

   // request sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pend_in       = pend_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      scan_in       = scan_ff;
      pend_idx_in   = pend_idx_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_index_in  = res_index_ff;
      res_data_in   = res_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = AW'(count_ff);
      ram_wr_data   = value_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = AW'(scan_ff);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in       = req_kind;
               value_in      = req_value;
               scan_in       = '0;
               pend_in       = 1'b0;
               res_status_in = STATUS_OK;
               res_found_in  = 1'b0;
               res_index_in  = '0;
               res_data_in   = '0;
               case (req_kind)
                  KIND_INSERT: begin
                     if (full) begin
                        res_status_in = STATUS_FULL;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  KIND_READ: begin
                     if (CNT_W'(req_position) < count_ff) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = AW'(req_position);
                        state_in    = S_READ;
                     end else begin
                        res_status_in = STATUS_RANGE;
                        state_in      = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_SCAN;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // one read per cycle, compare the previous one
            if (issue) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(scan_ff);
               scan_in     = CNT_W'(scan_ff + 1'b1);
               pend_in     = 1'b1;
               pend_idx_in = scan_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (hit) begin
               pend_in = 1'b0;
               case (kind_ff)
                  KIND_INSERT: begin
                     res_status_in = STATUS_DUP;
                     state_in      = S_DONE;
                  end
                  KIND_REMOVE: begin
                     res_found_in = 1'b1;
                     res_index_in = POS_W'(pend_idx_ff);
                     scan_in      = CNT_W'(pend_idx_ff + 1'b1);
                     state_in     = S_SHIFT;
                  end
                  default: begin
                     res_found_in = 1'b1;
                     res_index_in = POS_W'(pend_idx_ff);
                     state_in     = S_DONE;
                  end
               endcase
            end else if (!pend_ff && !issue) begin
               // value absent
               case (kind_ff)
                  KIND_INSERT: begin
                     ram_wr_en = 1'b1;
                     count_in  = CNT_W'(count_ff + 1'b1);
                  end
                  KIND_REMOVE: begin
                     res_status_in = STATUS_MISSING;
                  end
                  default: begin
                  end
               endcase
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            // read entry j+1, write it to j in the next cycle
            if (issue) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(scan_ff);
               scan_in     = CNT_W'(scan_ff + 1'b1);
               pend_in     = 1'b1;
               pend_idx_in = scan_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(pend_idx_ff - 1'b1);
               ram_wr_data = ram_rd_data;
            end
            if (!pend_ff && !issue) begin
               count_in = CNT_W'(count_ff - 1'b1);
               state_in = S_DONE;
            end
         end
         S_READ: begin
            res_data_in = ram_rd_data;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_index_in  = res_index_ff;
               rsp_data_in   = res_data_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         capacity_ff  <= CAP_RESET;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      scan_ff       <= scan_in;
      pend_idx_ff   <= pend_idx_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_index_ff  <= res_index_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // outputs
   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_read_value  = rsp_data_ff;
   assign rsp_count       = rsp_count_ff;

   // checks
   `BST_ASSERT(a_count_bound, clock, reset, int'(count_ff) <= DEPTH)
   `BST_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, state_ff != S_IDLE)
   `BST_ASSERT(a_write_owner, clock, reset, !ram_wr_en || state_ff == S_SCAN || state_ff == S_SHIFT)
   `BST_ASSERT_NEXT(a_rsp_load, clock, reset, state_ff == S_DONE && rsp_free, rsp_valid_ff)

endmodule

/* design/bst_ram.sv */
module bst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
   import bst_pkg::*;

   localparam int SET_DEPTH = DEPTH;

   // result of one request, field for field as the block returns it
   typedef struct packed {
      status_type        status;
      logic              found;
      logic [POS_W-1:0]  found_index;
      value_type         read_value;
      count_type         count;
   } set_result_type;

   logic              clock;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic              req_stall;
   logic [KIND_W-1:0] req_kind     = KIND_INSERT;
   logic signed [VAL_W-1:0] req_value = '0;
   logic [POS_W-1:0]  req_position = '0;
   logic              rsp_valid;
   logic              rsp_stall    = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic              rsp_found;
   logic [POS_W-1:0]  rsp_found_index;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic [CNT_W-1:0]  rsp_count;
   logic              csr_psel     = 1'b0;
   logic              csr_penable  = 1'b0;
   logic              csr_pwrite   = 1'b0;
   logic [CSR_AW-1:0] csr_paddr    = '0;
   logic [CSR_W-1:0]  csr_pwdata   = '0;
   logic [CSR_W-1:0]  csr_prdata;
   logic              csr_pready;

   // shadow copy of the set and its capacity
   value_type         set_mem [SET_DEPTH];
   int unsigned       set_count;
   int unsigned       set_cap;

   set_result_type    pending_responses [$];
   set_result_type    oldest_response;
   int unsigned       mismatches = 0;

   // sender burst bookkeeping
   int unsigned       burst_left = 0;

   // receiver stall pattern state
   int unsigned       stall_run  = 0;
   int unsigned       stall_mode = 0;

   bounded_set_table_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index),
      .rsp_read_value  (rsp_read_value),
      .rsp_count       (rsp_count),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

   // set state after reset
   function automatic void clear_set_model();
      for (int i = 0; i < SET_DEPTH; i++) set_mem[i] = '0;
      set_count = 0;
      set_cap   = 32'(CAP_RESET);
   endfunction

   // apply one request to the shadow set and return the response it should give
   function automatic set_result_type apply_request(input kind_type k, input value_type v,
                                                    input logic [POS_W-1:0] p);
      set_result_type r;
      int unsigned eff_cap;
      int unsigned hit_at;
      bit          hit;
      r       = '0;
      eff_cap = (set_cap > SET_DEPTH) ? SET_DEPTH : set_cap;
      hit     = 1'b0;
      hit_at  = 0;
      // linear search over the held elements
      for (int i = 0; i < set_count; i++) begin
         if (!hit && set_mem[i] == v) begin
            hit    = 1'b1;
            hit_at = i;
         end
      end
      case (k)
         KIND_INSERT: begin
            // fullness wins over a duplicate
            if (set_count >= eff_cap) r.status = STATUS_FULL;
            else if (hit) r.status = STATUS_DUP;
            else begin
               set_mem[set_count] = v;
               set_count++;
            end
         end
         KIND_REMOVE: begin
            if (hit) begin
               r.found       = 1'b1;
               r.found_index = hit_at[POS_W-1:0];
               // close the gap
               for (int j = hit_at; j + 1 < set_count; j++) set_mem[j] = set_mem[j+1];
               set_count--;
            end else begin
               r.status = STATUS_MISSING;
            end
         end
         KIND_TEST: begin
            if (hit) begin
               r.found       = 1'b1;
               r.found_index = hit_at[POS_W-1:0];
            end
         end
         default: begin
            if (p < set_count) r.read_value = set_mem[p];
            else r.status = STATUS_RANGE;
         end
      endcase
      r.count = set_count[CNT_W-1:0];
      return r;
   endfunction

   // send one request beat, record its expected response, then maybe pause
   task automatic send_request(input kind_type k, input value_type v,
                               input logic [POS_W-1:0] p);
      int unsigned gap;
      req_valid    <= 1'b1;
      req_kind     <= k;
      req_value    <= v;
      req_position <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_responses.push_back(apply_request(k, v, p));
      if (burst_left == 0) begin
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
         gap = $urandom_range(6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // let every outstanding response come back and the block go quiet
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // apb write of the capacity register, upper data bits random
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      logic [CSR_W-1:0] data;
      drain_responses();
      data            = $urandom;
      data[CAP_W-1:0] = cap;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_IDX_CAPACITY, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      set_cap = 32'(cap);
   endtask

   // requests on an empty set at reset capacity
   task automatic test_empty_set();
      send_request(KIND_READ,   32'h0000_0000, 4'd0);
      send_request(KIND_TEST,   32'h0000_0000, 4'd0);
      send_request(KIND_REMOVE, 32'h7fff_ffff, 4'd0);
      send_request(KIND_READ,   32'h0000_0000, 4'd15);
   endtask

   // fill to capacity, refusals, searches and compaction
   task automatic test_fill_and_refuse();
      send_request(KIND_INSERT, 32'h8000_0000, 4'd0);
      send_request(KIND_INSERT, 32'h7fff_ffff, 4'd0);
      send_request(KIND_INSERT, 32'h0000_0000, 4'd0);
      send_request(KIND_INSERT, 32'hffff_ffff, 4'd0);
      send_request(KIND_INSERT, 32'h0000_0000, 4'd0);
      send_request(KIND_INSERT, 32'h0000_0001, 4'd0);
      send_request(KIND_INSERT, 32'h0000_0002, 4'd0);
      // duplicate while full still reports full
      send_request(KIND_INSERT, 32'h7fff_ffff, 4'd0);
      send_request(KIND_TEST,   32'hffff_ffff, 4'd0);
      send_request(KIND_READ,   32'h0000_0000, 4'd4);
      send_request(KIND_READ,   32'h0000_0000, 4'd5);
      send_request(KIND_REMOVE, 32'h0000_0000, 4'd0);
      send_request(KIND_READ,   32'h0000_0000, 4'd2);
      send_request(KIND_REMOVE, 32'h8000_0000, 4'd0);
      send_request(KIND_REMOVE, 32'h0000_0001, 4'd0);
      send_request(KIND_TEST,   32'h0000_0001, 4'd0);
   endtask

   // capacity below the count, zero, and beyond the store
   task automatic test_capacity_extremes();
      write_capacity(5'd2);
      send_request(KIND_INSERT, 32'h0000_0005, 4'd0);
      send_request(KIND_INSERT, 32'h7fff_ffff, 4'd0);
      send_request(KIND_REMOVE, 32'hffff_ffff, 4'd0);
      write_capacity(5'd0);
      send_request(KIND_INSERT, 32'h0000_0009, 4'd0);
      send_request(KIND_READ,   32'h0000_0000, 4'd0);
      write_capacity(5'd31);
      send_request(KIND_INSERT, 32'h0000_0009, 4'd0);
      send_request(KIND_READ,   32'h0000_0000, 4'd1);
   endtask

   // one random request, biased toward values already held
   task automatic random_request(input int unsigned insert_pct);
      kind_type          k;
      value_type         v;
      logic [POS_W-1:0]  p;
      int unsigned       sel;
      if ($urandom_range(99) < insert_pct) begin
         k = KIND_INSERT;
      end else begin
         case ($urandom_range(2))
            0:       k = KIND_REMOVE;
            1:       k = KIND_TEST;
            default: k = KIND_READ;
         endcase
      end
      sel = $urandom_range(99);
      if (sel < 45 && set_count != 0) begin
         v = set_mem[$urandom_range(set_count - 1)];
      end else if (sel < 75) begin
         case ($urandom_range(4))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2:       v = 32'hffff_ffff;
            default: v = $urandom_range(7);
         endcase
      end else begin
         v = $urandom;
      end
      if ($urandom_range(3) != 0 && set_count != 0) p = POS_W'($urandom_range(set_count - 1));
      else p = POS_W'($urandom_range(15));
      send_request(k, v, p);
   endtask

   // phases of random traffic, alternating fill and drain pressure
   task automatic test_random_traffic();
      logic [CAP_W-1:0] caps [12];
      caps = '{5'd16, 5'd31, 5'd1, 5'd17, 5'd8, 5'd0, 5'd3, 5'd20, 5'd5, 5'd2, 5'd16, 5'd0};
      caps[11] = CAP_W'($urandom_range(31));
      for (int ph = 0; ph < 12; ph++) begin
         write_capacity(caps[ph]);
         for (int n = 0; n < 75; n++) random_request((ph % 2 == 0) ? 60 : 25);
      end
   endtask

   // receiver stall pattern: clear runs, random, solid holds, light
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(3);
         stall_run  = (stall_mode == 2) ? $urandom_range(1, 12) : $urandom_range(5, 60);
      end
      stall_run--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(1) == 1);
         2:       rsp_stall <= 1'b1;
         default: rsp_stall <= ($urandom_range(3) == 0);
      endcase
   end

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // response checker, in order against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            $error("response beat with no request outstanding");
            mismatches++;
         end else begin
            oldest_response = pending_responses.pop_front();
            compare_field("status", 32'(oldest_response.status), 32'(rsp_status));
            compare_field("found", 32'(oldest_response.found), 32'(rsp_found));
            compare_field("found_index", 32'(oldest_response.found_index),
                          32'(rsp_found_index));
            compare_field("read_value", oldest_response.read_value, rsp_read_value);
            compare_field("count", 32'(oldest_response.count), 32'(rsp_count));
         end
      end
   end

   // main sequence
   initial begin
      clear_set_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_set();
      test_fill_and_refuse();
      test_capacity_extremes();
      test_random_traffic();
      drain_responses();
      repeat (32) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
